>>> hdl/cdd_pkg.sv
// ----------------------------------------------------------------------------
// cdd_pkg: shared types and constants of the dueling dead-block replacer
// Row layout of the per-set state memory, set classes and counter limits.
// ----------------------------------------------------------------------------
package cdd_pkg;

	// geometry
	localparam int SETS        = 2048;
	localparam int WAYS        = 16;
	localparam int LEADER_SETS = 64;
	localparam int SEL_W       = 8;

	localparam int SET_W    = $clog2(SETS);
	localparam int WAY_W    = 4;
	localparam int CHANCE_W = 5;
	localparam int PERIOD_W = 12;

	localparam logic [PERIOD_W-1:0] PERIOD_MASK = 12'hFFF;

	// set classes by index
	localparam int LIP_LEAD_END = LEADER_SETS / 2;
	localparam int BIP_LEAD_END = LEADER_SETS;

	// two-bit counter limits
	localparam logic [1:0] CTR_MAX      = 2'd3;
	localparam logic [1:0] REUSE_STRONG = 2'd2;
	localparam logic [1:0] REUSE_FILL   = 2'd1;

	// duel selector bounds
	localparam logic [SEL_W-1:0] SEL_HALF  = SEL_W'(1) << (SEL_W - 1);
	localparam logic [SEL_W-1:0] SEL_MAX   = '1;

	localparam logic [WAY_W-1:0] POS_LRU = WAY_W'(WAYS - 1);
	localparam logic [WAY_W-1:0] POS_MRU = '0;

	// operation codes
	localparam logic OP_QUERY  = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef enum logic [1:0] {
		SET_LIP_LEAD = 2'd0,
		SET_BIP_LEAD = 2'd1,
		SET_FOLLOW   = 2'd2
	} set_kind_t;

	// one memory row holds all per-set state
	typedef struct packed {
		logic [WAYS-1:0][1:0]       dead;
		logic [WAYS-1:0][1:0]       reuse;
		logic [WAYS-1:0][WAY_W-1:0] pos;
	} row_t;

	// selector steering from one update
	typedef struct packed {
		logic inc;
		logic dec;
	} sel_ctl_t;

	localparam row_t ROW_RESET = '{
		dead:  '0,
		reuse: {WAYS{REUSE_FILL}},
		pos:   '0
	};

	// age every dead counter of a row by one, stopping at zero
	function automatic row_t decay_row(row_t r);
		row_t o;
		o = r;
		for (int k = 0; k < WAYS; k++) begin
			if (r.dead[k] != 2'd0)
				o.dead[k] = r.dead[k] - 2'd1;
		end
		return o;
	endfunction

endpackage

>>> hdl/cdd_row_mem.sv
// ----------------------------------------------------------------------------
// cdd_row_mem: per-set state memory
// One write port and one read port, read data registered and held while idle.
// ----------------------------------------------------------------------------
module cdd_row_mem (
	input  logic                    clk,
	input  logic                    wr_en,
	input  logic [cdd_pkg::SET_W-1:0] wr_addr,
	input  cdd_pkg::row_t           wr_data,
	input  logic                    rd_en,
	input  logic [cdd_pkg::SET_W-1:0] rd_addr,
	output cdd_pkg::row_t           rd_data
);
	import cdd_pkg::*;

	row_t mem [SETS];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

>>> hdl/cdd_victim.sv
// ----------------------------------------------------------------------------
// cdd_victim: victim way selection
// First invalid way, else the highest way holding the oldest recency position.
// ----------------------------------------------------------------------------
module cdd_victim (
	input  logic [cdd_pkg::WAYS-1:0]                    valid_mask,
	input  logic [cdd_pkg::WAYS-1:0][cdd_pkg::WAY_W-1:0] pos,
	output logic [cdd_pkg::WAY_W-1:0]                   victim_way
);
	import cdd_pkg::*;

	localparam int LVLS = WAY_W;
	localparam int NP   = 1 << WAY_W;

	logic             inv_found;
	logic [WAY_W-1:0] inv_way;
	logic [WAY_W-1:0] t_pos [LVLS+1][NP];
	logic [WAY_W-1:0] t_idx [LVLS+1][NP];
	logic             t_en  [LVLS+1][NP];

	// lowest-numbered invalid way
	always_comb begin
		inv_found = 1'b0;
		inv_way   = '0;
		for (int k = WAYS - 1; k >= 0; k--) begin
			if (!valid_mask[k]) begin
				inv_found = 1'b1;
				inv_way   = WAY_W'(k);
			end
		end
	end

	// oldest-position tree, ties go to the higher way
	always_comb begin
		for (int l = 0; l <= LVLS; l++) begin
			for (int k = 0; k < NP; k++) begin
				t_pos[l][k] = '0;
				t_idx[l][k] = '0;
				t_en[l][k]  = 1'b0;
			end
		end
		for (int k = 0; k < WAYS; k++) begin
			t_pos[0][k] = pos[k];
			t_idx[0][k] = WAY_W'(k);
			t_en[0][k]  = 1'b1;
		end
		for (int l = 0; l < LVLS; l++) begin
			for (int k = 0; k < (NP >> (l + 1)); k++) begin
				if (t_en[l][2*k+1] && (t_pos[l][2*k+1] >= t_pos[l][2*k])) begin
					t_pos[l+1][k] = t_pos[l][2*k+1];
					t_idx[l+1][k] = t_idx[l][2*k+1];
				end else begin
					t_pos[l+1][k] = t_pos[l][2*k];
					t_idx[l+1][k] = t_idx[l][2*k];
				end
				t_en[l+1][k] = t_en[l][2*k] | t_en[l][2*k+1];
			end
		end
	end

	assign victim_way = inv_found ? inv_way : t_idx[LVLS][0];

endmodule

>>> hdl/cdd_upd.sv
// ----------------------------------------------------------------------------
// cdd_upd: row update on a hit or a miss fill
// Recency move, reuse and dead counters, insertion depth and selector steering.
// ----------------------------------------------------------------------------
module cdd_upd (
	input  cdd_pkg::row_t              row_in,
	input  logic [cdd_pkg::WAY_W-1:0]  way,
	input  logic                       hit,
	input  logic [cdd_pkg::CHANCE_W-1:0] chance,
	input  cdd_pkg::set_kind_t         kind,
	input  logic                       sel_lip,
	output cdd_pkg::row_t              row_out,
	output cdd_pkg::sel_ctl_t          sel_ctl
);
	import cdd_pkg::*;

	logic [WAY_W-1:0] old_pos;
	logic [WAY_W-1:0] bip_pos;
	logic [WAY_W-1:0] ins_pos;
	logic [WAY_W-1:0] new_pos;
	logic [1:0]       r;
	logic [1:0]       d;
	logic [1:0]       d_inc;

	// insertion depth by set class and overrides
	always_comb begin
		old_pos = row_in.pos[way];
		r       = row_in.reuse[way];
		d       = row_in.dead[way];
		d_inc   = (d < CTR_MAX) ? d + 2'd1 : d;
		bip_pos = (chance == '0) ? POS_MRU : POS_LRU;
		unique case (kind)
			SET_LIP_LEAD: ins_pos = POS_LRU;
			SET_BIP_LEAD: ins_pos = bip_pos;
			SET_FOLLOW:   ins_pos = sel_lip ? POS_LRU : bip_pos;
			default:      ins_pos = sel_lip ? POS_LRU : bip_pos;
		endcase
		if (r >= REUSE_STRONG)
			ins_pos = POS_MRU;
		if (d_inc == CTR_MAX)
			ins_pos = POS_LRU;
		new_pos = hit ? POS_MRU : ins_pos;
	end

	// new row contents
	always_comb begin
		row_out = row_in;
		for (int k = 0; k < WAYS; k++) begin
			if (row_in.pos[k] < old_pos)
				row_out.pos[k] = row_in.pos[k] + WAY_W'(1);
		end
		row_out.pos[way] = new_pos;
		if (hit) begin
			if (r < CTR_MAX)
				row_out.reuse[way] = r + 2'd1;
			row_out.dead[way] = 2'd0;
		end else begin
			row_out.dead[way]  = d_inc;
			row_out.reuse[way] = REUSE_FILL;
		end
	end

	// leader misses steer the selector
	always_comb begin
		sel_ctl.dec = !hit && (kind == SET_LIP_LEAD);
		sel_ctl.inc = !hit && (kind == SET_BIP_LEAD);
	end

endmodule

>>> hdl/cache_replacement_dueling_deadblock_top.sv
// ----------------------------------------------------------------------------
// cache_replacement_dueling_deadblock_top: set-dueling dead-block replacer
// Victim queries and replacement state updates against a per-set row memory.
//
//   channel | handshake          | payload
//   --------+--------------------+---------------------------------------------
//   input   | in_valid/in_ready  | op, set_index, way_index, hit, valid_mask,
//           |                    | chance_bits
//   output  | out_valid/out_ready| victim_way
//
// An item is accepted in IDLE, which reads its set row; EXEC then modifies
// and writes the row back and loads the output register, and no new item is
// accepted until it returns to IDLE. A full output register holds EXEC until
// the result is taken. Every 4096th update first runs a decay sweep over the
// row memory, one row a cycle, with no item accepted.
// After reset a clearing pass writes the reset row to every set.
// ----------------------------------------------------------------------------
module cache_replacement_dueling_deadblock_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          op,
	input  logic [cdd_pkg::SET_W-1:0]     set_index,
	input  logic [cdd_pkg::WAY_W-1:0]     way_index,
	input  logic                          hit,
	input  logic [cdd_pkg::WAYS-1:0]      valid_mask,
	input  logic [cdd_pkg::CHANCE_W-1:0]  chance_bits,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [cdd_pkg::WAY_W-1:0]     victim_way
);
	import cdd_pkg::*;

	typedef enum logic [4:0] {
		ST_INIT   = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_EXEC   = 5'b00100,
		ST_SWEEP  = 5'b01000,
		ST_REREAD = 5'b10000
	} state_t;

	state_t             state_q, state_d;
	logic [SET_W:0]     ptr_q;
	logic [SET_W-1:0]   sw_addr_q;
	logic               sw_wv_q;
	logic               decayed_q;
	logic [PERIOD_W-1:0] upd_cnt_q;
	logic [SEL_W-1:0]   sel_q;
	logic               out_valid_q;
	logic [WAY_W-1:0]   victim_q;

	// captured item
	logic               op_q;
	logic [SET_W-1:0]   set_q;
	logic [WAY_W-1:0]   way_q;
	logic               hit_q;
	logic [WAYS-1:0]    valid_q;
	logic [CHANCE_W-1:0] chance_q;

	logic               accept;
	logic               way_ok;
	logic               upd_ok;
	logic               need_decay;
	logic               exec_go;
	logic               sweep_rd;
	logic               sweep_end;
	set_kind_t          kind;

	logic               mem_wr_en;
	logic [SET_W-1:0]   mem_wr_addr;
	row_t               mem_wr_data;
	logic               mem_rd_en;
	logic [SET_W-1:0]   mem_rd_addr;
	row_t               mem_rd_data;
	row_t               upd_row;
	sel_ctl_t           sel_ctl;
	logic [WAY_W-1:0]   vic_way;

	assign in_ready   = (state_q == ST_IDLE);
	assign accept     = in_valid && in_ready;
	assign out_valid  = out_valid_q;
	assign victim_way = victim_q;

	// item decode
	assign way_ok     = (32'(way_q) < WAYS);
	assign upd_ok     = (op_q == OP_UPDATE) && way_ok;
	assign need_decay = (state_q == ST_EXEC) && upd_ok && (upd_cnt_q == PERIOD_MASK)
	                    && !decayed_q;
	assign exec_go    = (state_q == ST_EXEC) && !need_decay && (!out_valid_q || out_ready);
	assign sweep_rd   = (state_q == ST_SWEEP) && (32'(ptr_q) < SETS);
	assign sweep_end  = (state_q == ST_SWEEP) && !sweep_rd && !sw_wv_q;

	// set class
	always_comb begin
		if (32'(set_q) < LIP_LEAD_END)
			kind = SET_LIP_LEAD;
		else if (32'(set_q) < BIP_LEAD_END)
			kind = SET_BIP_LEAD;
		else
			kind = SET_FOLLOW;
	end

	// memory port selection
	always_comb begin
		mem_wr_en   = 1'b0;
		mem_wr_addr = set_q;
		mem_wr_data = upd_row;
		if (state_q == ST_INIT) begin
			mem_wr_en   = 1'b1;
			mem_wr_addr = ptr_q[SET_W-1:0];
			mem_wr_data = ROW_RESET;
		end else if (state_q == ST_SWEEP) begin
			mem_wr_en   = sw_wv_q;
			mem_wr_addr = sw_addr_q;
			mem_wr_data = decay_row(mem_rd_data);
		end else if (exec_go && upd_ok) begin
			mem_wr_en = 1'b1;
		end
	end

	always_comb begin
		mem_rd_en   = 1'b0;
		mem_rd_addr = set_index;
		if (accept) begin
			mem_rd_en = 1'b1;
		end else if (sweep_rd) begin
			mem_rd_en   = 1'b1;
			mem_rd_addr = ptr_q[SET_W-1:0];
		end else if (state_q == ST_REREAD) begin
			mem_rd_en   = 1'b1;
			mem_rd_addr = set_q;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (ptr_q[SET_W-1:0] == SET_W'(SETS - 1))
					state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept)
					state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (need_decay)
					state_d = ST_SWEEP;
				else if (exec_go)
					state_d = ST_IDLE;
			end
			ST_SWEEP: begin
				if (sweep_end)
					state_d = ST_REREAD;
			end
			ST_REREAD: state_d = ST_EXEC;
			default:   state_d = ST_INIT;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			ptr_q       <= '0;
			sw_addr_q   <= '0;
			sw_wv_q     <= 1'b0;
			decayed_q   <= 1'b0;
			upd_cnt_q   <= '0;
			sel_q       <= SEL_HALF;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			// clearing pass and sweep pointer
			if (state_q == ST_INIT) begin
				ptr_q <= (state_d == ST_IDLE) ? '0 : ptr_q + 1'b1;
			end else if (need_decay) begin
				ptr_q <= '0;
			end else if (sweep_rd) begin
				ptr_q <= ptr_q + 1'b1;
			end

			// sweep write-back comes in the cycle after its read
			sw_wv_q <= sweep_rd;
			if (sweep_rd)
				sw_addr_q <= ptr_q[SET_W-1:0];

			if (need_decay)
				decayed_q <= 1'b1;
			else if (exec_go)
				decayed_q <= 1'b0;

			// update counter and duel selector
			if (exec_go && upd_ok) begin
				upd_cnt_q <= upd_cnt_q + 1'b1;
				if (sel_ctl.dec && (sel_q != '0))
					sel_q <= sel_q - 1'b1;
				else if (sel_ctl.inc && (sel_q != SEL_MAX))
					sel_q <= sel_q + 1'b1;
			end

			// output register
			if (exec_go)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= op;
			set_q    <= set_index;
			way_q    <= way_index;
			hit_q    <= hit;
			valid_q  <= valid_mask;
			chance_q <= chance_bits;
		end
		if (exec_go)
			victim_q <= (op_q == OP_QUERY) ? vic_way : '0;
	end

	cdd_row_mem u_mem (
		.clk     (clk),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data),
		.rd_en   (mem_rd_en),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data)
	);

	cdd_victim u_victim (
		.valid_mask (valid_q),
		.pos        (mem_rd_data.pos),
		.victim_way (vic_way)
	);

	cdd_upd u_upd (
		.row_in  (mem_rd_data),
		.way     (way_q),
		.hit     (hit_q),
		.chance  (chance_q),
		.kind    (kind),
		.sel_lip (sel_q >= SEL_HALF),
		.row_out (upd_row),
		.sel_ctl (sel_ctl)
	);

`ifndef SYNTHESIS
	// no item is taken during the clearing pass or a sweep
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_INIT) || (state_q == ST_SWEEP)) |-> !in_ready)
		else $error("item accepted during clearing pass or sweep");

	// the row memory is never written while waiting for an item
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_wr_en)
		else $error("row memory written while idle");

	// the selector moves only after a completed miss fill
	a_sel_on_miss: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(sel_q) |-> $past(exec_go && upd_ok && !hit_q))
		else $error("selector moved without a miss fill");

	// the wrapping update has always been preceded by its decay sweep
	a_decay_first: assert property (@(posedge clk) disable iff (!arst_n)
		(exec_go && upd_ok && (upd_cnt_q == PERIOD_MASK)) |-> decayed_q)
		else $error("period wrap without decay sweep");
`endif

endmodule

>>> dv/cache_replacement_dueling_deadblock_top_tb.sv
// ----------------------------------------------------------------------------
// cache_replacement_dueling_deadblock_top_tb: replacer testbench
// Drives victim queries and replacement updates through the input handshake,
// keeps its own copy of the recency, reuse and dead counters and the duel
// selector, and checks every victim returned against that copy. Random gaps
// and stalls on both sides; leader-biased phases push the selector toward both
// bounds, and an update-heavy phase builds up counter state in the hot sets.
// ----------------------------------------------------------------------------
module cache_replacement_dueling_deadblock_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import cdd_pkg::*;

	localparam int WATCHDOG_LIMIT = 12000;
	localparam int PHASE_ITEMS    = 1700;
	localparam int SEGMENT_ITEMS  = 425;

	// stimulus modes
	localparam int MODE_MIXED    = 0;
	localparam int MODE_LIP_BIAS = 1;
	localparam int MODE_BIP_BIAS = 2;
	localparam int MODE_UPDATES  = 3;

	// one pending item with its lead-in gap
	typedef struct packed {
		logic                op;
		logic [SET_W-1:0]    set_index;
		logic [WAY_W-1:0]    way_index;
		logic                hit;
		logic [WAYS-1:0]     valid_mask;
		logic [CHANCE_W-1:0] chance_bits;
		logic [2:0]          gap;
		logic                drain;
	} access_t;

	logic                clk         = 1'b0;
	logic                arst_n      = 1'b0;
	logic                in_valid    = 1'b0;
	logic                in_ready;
	logic                op          = OP_QUERY;
	logic [SET_W-1:0]    set_index   = '0;
	logic [WAY_W-1:0]    way_index   = '0;
	logic                hit         = 1'b0;
	logic [WAYS-1:0]     valid_mask  = '0;
	logic [CHANCE_W-1:0] chance_bits = '0;
	logic                out_valid;
	logic                out_ready   = 1'b0;
	logic [WAY_W-1:0]    victim_way;

	// predicted replacement state
	logic [WAYS-1:0][WAY_W-1:0] set_recency [SETS];
	logic [WAYS-1:0][1:0]       set_reuse   [SETS];
	logic [WAYS-1:0][1:0]       set_dead    [SETS];
	logic [SEL_W-1:0]           duel_sel;
	logic [PERIOD_W-1:0]        update_cnt;

	access_t          access_q [$];
	logic [WAY_W-1:0] victim_q [$];

	access_t drv_item;
	logic    drv_busy;
	int      drv_wait;
	bit      gap_quiet;
	bit      hold_next;
	bit      mon_quiet;
	int      mon_stall;
	int      quiet_cycles;
	int      mismatches;
	int      n_queries, n_hits, n_misses, n_decays;
	int      sel_lo, sel_hi;

	cache_replacement_dueling_deadblock_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.op          (op),
		.set_index   (set_index),
		.way_index   (way_index),
		.hit         (hit),
		.valid_mask  (valid_mask),
		.chance_bits (chance_bits),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.victim_way  (victim_way)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_mismatch(input string msg);
		mismatches++;
		$display("mismatch at %0t ns: %s", $time, msg);
	endtask

	// move a way to a new recency position; younger ways age by one
	task automatic move_way(input int s, input int w, input logic [WAY_W-1:0] newpos);
		logic [WAYS-1:0][WAY_W-1:0] row;
		logic [WAY_W-1:0]           old;
		int                         k;
		row = set_recency[s];
		old = row[w];
		for (k = 0; k < WAYS; k++) begin
			if (row[k] < old)
				row[k] = row[k] + 1'b1;
		end
		row[w] = newpos;
		set_recency[s] = row;
	endtask

	// apply one accepted item to the predicted state and queue its victim
	task automatic apply_access(input access_t a);
		logic [WAY_W-1:0]           res, best, ins, bip_pos;
		logic [WAYS-1:0][1:0]       dword;
		logic [WAYS-1:0][1:0]       rword;
		logic [WAYS-1:0][WAY_W-1:0] row;
		logic [1:0]                 d;
		set_kind_t                  kind;
		bit                         found;
		int                         s, w, k, j;
		s   = int'(a.set_index) % SETS;
		w   = int'(a.way_index);
		res = '0;
		if (a.op == OP_QUERY) begin
			n_queries++;
			found = 1'b0;
			// first invalid way wins
			for (k = 0; k < WAYS; k++) begin
				if (!found && !a.valid_mask[k]) begin
					res   = WAY_W'(k);
					found = 1'b1;
				end
			end
			// otherwise the last way at the deepest position
			if (!found) begin
				row  = set_recency[s];
				best = '0;
				for (k = 0; k < WAYS; k++) begin
					if (row[k] >= best) begin
						best = row[k];
						res  = WAY_W'(k);
					end
				end
			end
		end else if (w < WAYS) begin
			update_cnt = (update_cnt + 1'b1) & PERIOD_MASK;
			// periodic decay of every dead counter
			if (update_cnt == '0) begin
				n_decays++;
				for (j = 0; j < SETS; j++) begin
					dword = set_dead[j];
					for (k = 0; k < WAYS; k++) begin
						if (dword[k] != 2'd0)
							dword[k] = dword[k] - 2'd1;
					end
					set_dead[j] = dword;
				end
			end
			rword = set_reuse[s];
			dword = set_dead[s];
			if (a.hit) begin
				n_hits++;
				move_way(s, w, POS_MRU);
				if (rword[w] < CTR_MAX)
					rword[w] = rword[w] + 2'd1;
				dword[w] = 2'd0;
			end else begin
				n_misses++;
				d = dword[w];
				if (d < CTR_MAX)
					d = d + 2'd1;
				dword[w] = d;
				kind = (s < LIP_LEAD_END) ? SET_LIP_LEAD :
				       (s < BIP_LEAD_END) ? SET_BIP_LEAD : SET_FOLLOW;
				bip_pos = (a.chance_bits == '0) ? POS_MRU : POS_LRU;
				case (kind)
					SET_LIP_LEAD: ins = POS_LRU;
					SET_BIP_LEAD: ins = bip_pos;
					default:      ins = (duel_sel >= SEL_HALF) ? POS_LRU : bip_pos;
				endcase
				// reuse and dead overrides, dead last
				if (rword[w] >= REUSE_STRONG)
					ins = POS_MRU;
				if (d == CTR_MAX)
					ins = POS_LRU;
				move_way(s, w, ins);
				rword[w] = REUSE_FILL;
				// leader misses steer the selector
				if (kind == SET_LIP_LEAD && duel_sel != '0)
					duel_sel = duel_sel - 1'b1;
				else if (kind == SET_BIP_LEAD && duel_sel != SEL_MAX)
					duel_sel = duel_sel + 1'b1;
				if (int'(duel_sel) < sel_lo)
					sel_lo = int'(duel_sel);
				if (int'(duel_sel) > sel_hi)
					sel_hi = int'(duel_sel);
			end
			set_reuse[s] = rword;
			set_dead[s]  = dword;
		end
		victim_q.push_back(res);
	endtask

	// queue one item with a random lead-in gap
	task automatic add_access(input logic o, input logic [SET_W-1:0] s,
			input logic [WAY_W-1:0] w, input logic h, input logic [WAYS-1:0] m,
			input logic [CHANCE_W-1:0] c);
		access_t a;
		a.op          = o;
		a.set_index   = s;
		a.way_index   = w;
		a.hit         = h;
		a.valid_mask  = m;
		a.chance_bits = c;
		a.gap         = gap_quiet ? 3'd0 : 3'($urandom_range(6));
		a.drain       = hold_next;
		hold_next     = 1'b0;
		if ($urandom_range(39) == 0)
			gap_quiet = !gap_quiet;
		access_q.push_back(a);
	endtask

	// a few hot sets per class so state builds up, sometimes any set
	function automatic logic [SET_W-1:0] pick_set(input int cls);
		int r;
		r = $urandom_range(2);
		if ($urandom_range(9) == 0)
			return SET_W'($urandom_range(SETS - 1));
		case (cls)
			0:       return (r == 0) ? SET_W'(0)  : (r == 1) ? SET_W'(9)    : SET_W'(31);
			1:       return (r == 0) ? SET_W'(32) : (r == 1) ? SET_W'(50)   : SET_W'(63);
			default: return (r == 0) ? SET_W'(64) : (r == 1) ? SET_W'(1234) : SET_W'(2047);
		endcase
	endfunction

	// one random item shaped by the stimulus mode
	task automatic add_random(input int mode);
		logic [CHANCE_W-1:0] c;
		logic [WAYS-1:0]     m;
		int                  qpct, r;
		c    = ($urandom_range(3) == 0) ? '0 : CHANCE_W'($urandom);
		qpct = (mode == MODE_UPDATES) ? 20 : 40;
		if ((mode == MODE_LIP_BIAS || mode == MODE_BIP_BIAS) && $urandom_range(99) < 50) begin
			add_access(OP_UPDATE, pick_set(mode - 1), WAY_W'($urandom_range(15)), 1'b0,
				WAYS'($urandom), c);
		end else if ($urandom_range(99) < qpct) begin
			r = $urandom_range(99);
			if (r < 70)
				m = '1;
			else if (r < 85)
				m = ~(WAYS'(1) << $urandom_range(WAYS - 1));
			else
				m = WAYS'($urandom);
			add_access(OP_QUERY, pick_set($urandom_range(2)), WAY_W'($urandom), 1'($urandom),
				m, c);
		end else begin
			add_access(OP_UPDATE, pick_set($urandom_range(2)), WAY_W'($urandom_range(15)),
				($urandom_range(99) < 40), WAYS'($urandom), c);
		end
	endtask

	// driver: presents queued items, predicts on acceptance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			drv_wait = 0;
		end else begin
			drv_busy = in_valid;
			if (in_valid && in_ready) begin
				apply_access(drv_item);
				drv_busy = 1'b0;
			end
			if (!drv_busy && access_q.size() > 0) begin
				if (drv_wait < int'(access_q[0].gap)) begin
					drv_wait++;
				end else if (!(access_q[0].drain && victim_q.size() > 0)) begin
					drv_item    = access_q.pop_front();
					op          <= drv_item.op;
					set_index   <= drv_item.set_index;
					way_index   <= drv_item.way_index;
					hit         <= drv_item.hit;
					valid_mask  <= drv_item.valid_mask;
					chance_bits <= drv_item.chance_bits;
					drv_wait    = 0;
					drv_busy    = 1'b1;
				end
			end
			in_valid <= drv_busy;
		end
	end

	// monitor: checks each result against the oldest predicted victim
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			mon_stall = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (victim_q.size() == 0)
					report_mismatch($sformatf("victim_way %0d with no item pending",
						victim_way));
				else if (victim_way !== victim_q[0])
					report_mismatch($sformatf("victim_way got %0d expected %0d",
						victim_way, victim_q.pop_front()));
				else
					void'(victim_q.pop_front());
				mon_stall = mon_quiet ? 0 : $urandom_range(6);
				if ($urandom_range(39) == 0)
					mon_quiet = !mon_quiet;
			end
			if (mon_stall > 0) begin
				mon_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
			$display("** cache_replacement_dueling_deadblock_top: FAILED **");
			$finish;
		end
	end

	initial begin
		int s, n;
		// predicted state after reset
		for (s = 0; s < SETS; s++) begin
			set_recency[s] = '0;
			set_reuse[s]   = {WAYS{REUSE_FILL}};
			set_dead[s]    = '0;
		end
		duel_sel   = SEL_HALF;
		update_cnt = '0;
		sel_lo     = int'(SEL_HALF);
		sel_hi     = int'(SEL_HALF);

		// directed: fresh-set queries, mask extremes
		add_access(OP_QUERY, SET_W'(0), '0, 1'b0, '1, '0);
		add_access(OP_QUERY, SET_W'(2047), '1, 1'b1, '0, '1);
		add_access(OP_QUERY, SET_W'(1), '0, 1'b0, 16'h7FFF, '0);
		add_access(OP_QUERY, SET_W'(1), '0, 1'b0, 16'hFFFE, '0);
		// repeated misses on one way reach the dead override
		add_access(OP_UPDATE, SET_W'(0), WAY_W'(0), 1'b0, '0, '0);
		add_access(OP_UPDATE, SET_W'(0), WAY_W'(0), 1'b0, '0, '0);
		add_access(OP_UPDATE, SET_W'(0), WAY_W'(0), 1'b0, '0, '0);
		add_access(OP_UPDATE, SET_W'(0), WAY_W'(3), 1'b1, '0, '0);
		// strong reuse forces an insertion at mru
		add_access(OP_UPDATE, SET_W'(40), WAY_W'(1), 1'b1, '0, '1);
		add_access(OP_UPDATE, SET_W'(40), WAY_W'(1), 1'b1, '0, '1);
		add_access(OP_UPDATE, SET_W'(40), WAY_W'(1), 1'b0, '0, '1);
		// bimodal leader with and without the mru chance
		add_access(OP_UPDATE, SET_W'(32), WAY_W'(5), 1'b0, '0, '0);
		add_access(OP_UPDATE, SET_W'(32), WAY_W'(6), 1'b0, '0, '1);
		// follower sets, one at the top of the index range
		add_access(OP_UPDATE, SET_W'(2047), WAY_W'(15), 1'b0, '1, 5'd1);
		add_access(OP_UPDATE, SET_W'(2047), WAY_W'(14), 1'b0, '1, '0);
		add_access(OP_UPDATE, SET_W'(100), WAY_W'(15), 1'b1, '1, '1);
		hold_next = 1'b1;
		add_access(OP_QUERY, SET_W'(0), '0, 1'b0, '1, '0);
		add_access(OP_QUERY, SET_W'(32), '0, 1'b0, '1, '0);
		add_access(OP_QUERY, SET_W'(40), '0, 1'b0, '1, '0);
		add_access(OP_QUERY, SET_W'(2047), '0, 1'b0, '1, '0);
		add_access(OP_QUERY, SET_W'(100), '0, 1'b0, 16'h8000, '0);

		// random: lip-biased, bip-biased, mixed, then update-heavy segments
		for (n = 0; n < PHASE_ITEMS; n++) begin
			if (n % SEGMENT_ITEMS == 0)
				hold_next = 1'b1;
			case ((n / SEGMENT_ITEMS) % 4)
				0:       add_random(MODE_LIP_BIAS);
				1:       add_random(MODE_BIP_BIAS);
				2:       add_random(MODE_MIXED);
				default: add_random(MODE_UPDATES);
			endcase
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (access_q.size() > 0 || in_valid)
			@(posedge clk);
		while (victim_q.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d victim queries, %0d hits and %0d miss fills",
			n_queries, n_hits, n_misses);
		$display("dead counter decay sweeps: %0d, duel selector range %0d..%0d",
			n_decays, sel_lo, sel_hi);
		if (mismatches == 0)
			$display("** cache_replacement_dueling_deadblock_top: PASSED **");
		else
			$display("** cache_replacement_dueling_deadblock_top: FAILED **");
		$finish;
	end

endmodule
